// ----- src/tapsl_pkg.sv -----
`default_nettype none
package tapsl_pkg;

	// Register indexes of the configuration port
	localparam int unsigned CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CUT_AXIS    = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PLANE_LEVEL = 2'd1;

	// Axis codes
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	localparam int unsigned NUM_VERT = 3;

endpackage
`default_nettype wire

// ----- src/tapsl_if.sv -----
`default_nettype none

interface tapsl_vtx_if #(parameter int unsigned COORD_BITS = 32);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] v0_x;
	logic signed [COORD_BITS-1:0] v0_y;
	logic signed [COORD_BITS-1:0] v0_z;
	logic signed [COORD_BITS-1:0] v1_x;
	logic signed [COORD_BITS-1:0] v1_y;
	logic signed [COORD_BITS-1:0] v1_z;
	logic signed [COORD_BITS-1:0] v2_x;
	logic signed [COORD_BITS-1:0] v2_y;
	logic signed [COORD_BITS-1:0] v2_z;
	modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
		input ready);
	modport sink (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
		output ready);
endinterface

interface tapsl_seg_if #(parameter int unsigned COORD_BITS = 32);
	logic                         valid;
	logic                         ready;
	logic                         hit;
	logic signed [COORD_BITS-1:0] p0_x;
	logic signed [COORD_BITS-1:0] p0_y;
	logic signed [COORD_BITS-1:0] p0_z;
	logic signed [COORD_BITS-1:0] p1_x;
	logic signed [COORD_BITS-1:0] p1_y;
	logic signed [COORD_BITS-1:0] p1_z;
	modport source (output valid, hit, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, input ready);
	modport sink (input valid, hit, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, output ready);
endinterface

interface tapsl_cfg_if #(parameter int unsigned COORD_BITS = 32);
	logic                              valid;
	logic                              ready;
	logic [tapsl_pkg::CFG_IDX_BITS-1:0] idx;
	logic [COORD_BITS-1:0]             data;
	modport source (output valid, idx, data, input ready);
	modport sink (input valid, idx, data, output ready);
endinterface

`default_nettype wire

// ----- src/triangle_axis_plane_slicer.sv -----
`default_nettype none
// Throughput: one triangle per cycle unless a result waits on seg; the ratio
// divider is unrolled into FRAC_BITS + 1 pipeline stages, one quotient bit each,
// so nothing is shared. The whole pipe advances together; it holds only while a
// result waits on seg.
// Reset (arst_n low, asynchronous): all stage valid bits clear, cut_axis and
// plane_level return to zero. Payload registers are not reset.
module triangle_axis_plane_slicer #(
	parameter int unsigned COORD_BITS = 32,
	parameter int unsigned FRAC_BITS  = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	tapsl_cfg_if.sink   cfg,
	tapsl_vtx_if.sink   vtx,
	tapsl_seg_if.source seg
);
	import tapsl_pkg::*;

	localparam int unsigned CW = COORD_BITS;
	localparam int unsigned XW = COORD_BITS + 1;   // differences and magnitudes
	localparam int unsigned QW = FRAC_BITS + 1;    // ratio, up to 1.0
	localparam int unsigned HW = XW - FRAC_BITS;   // integer part of a magnitude
	localparam int unsigned ND = FRAC_BITS + 1;    // divider stages
	localparam int unsigned NS = ND + 4;           // all stages

	// One cut slot: start vertex, edge deltas and the interpolation ratio state
	typedef struct packed {
		logic [NUM_VERT-1:0][CW-1:0] a;
		logic [NUM_VERT-1:0][XW-1:0] dm;    // |a - b| per coordinate
		logic [NUM_VERT-1:0]         dn;    // a - b negative
		logic                        rneg;
		logic                        flat;
	} slot_t;

	typedef struct packed {
		logic [CW-1:0] lvl;
		logic [1:0]    ax;
		logic          hit;
	} com_t;

	typedef struct packed {
		slot_t         sl;
		logic [XW-1:0] rem;
		logic [XW-1:0] den;
		logic [QW-1:0] q;
	} dslot_t;

	typedef struct packed {
		com_t            c;
		dslot_t [1:0]    s;
	} div_t;

	typedef struct packed {
		slot_t                       sl;
		logic [NUM_VERT-1:0][QW+HW-1:0]        phi;
		logic [NUM_VERT-1:0][QW+FRAC_BITS-1:0] plo;
	} mslot_t;

	typedef struct packed {
		com_t         c;
		mslot_t [1:0] s;
	} mul_t;

	// ---------------------------------------------------------------------
	// Configuration: always ready; user rule: written only while the pipe is idle
	// ---------------------------------------------------------------------
	logic [1:0]    cut_axis_q;
	logic [CW-1:0] plane_level_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cut_axis_q    <= AXIS_X;
			plane_level_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.idx)
				CFG_CUT_AXIS:    cut_axis_q    <= cfg.data[1:0];
				CFG_PLANE_LEVEL: plane_level_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Unused axis code behaves as z
	logic [1:0] axis_eff;
	assign axis_eff = (cut_axis_q == 2'd3) ? AXIS_Z : cut_axis_q;

	// ---------------------------------------------------------------------
	// Pipeline control: one enable for every stage
	// ---------------------------------------------------------------------
	logic [NS-1:0] vld_q;
	logic          en;

	assign en        = !vld_q[NS-1] || seg.ready;
	assign vtx.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NS-2:0], vtx.valid};
		end
	end

	// ---------------------------------------------------------------------
	// Stage 1: register the triangle and test each edge against the level
	// ---------------------------------------------------------------------
	logic [NUM_VERT-1:0][NUM_VERT-1:0][CW-1:0] vin;
	logic [NUM_VERT-1:0]                       btw_in;

	assign vin[0] = {vtx.v0_z, vtx.v0_y, vtx.v0_x};
	assign vin[1] = {vtx.v1_z, vtx.v1_y, vtx.v1_x};
	assign vin[2] = {vtx.v2_z, vtx.v2_y, vtx.v2_x};

	always_comb begin
		logic signed [CW-1:0] l, ea, eb;
		l = $signed(plane_level_q);
		for (int i = 0; i < NUM_VERT; i++) begin
			ea = $signed(vin[i][axis_eff]);
			eb = $signed(vin[(i + 1) % NUM_VERT][axis_eff]);
			btw_in[i] = (l >= ea && l <= eb) || (l >= eb && l <= ea);
		end
	end

	logic [NUM_VERT-1:0][NUM_VERT-1:0][CW-1:0] v_s1;
	logic [NUM_VERT-1:0]                       btw_s1;
	logic [CW-1:0]                             lvl_s1;
	logic [1:0]                                ax_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1   <= vin;
			btw_s1 <= btw_in;
			lvl_s1 <= plane_level_q;
			ax_s1  <= axis_eff;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 2: pick the first two cut edges, form deltas and magnitudes
	// ---------------------------------------------------------------------
	function automatic logic [XW-1:0] mag_x(input logic [XW-1:0] v);
		return v[XW-1] ? (~v + 1'b1) : v;
	endfunction

	div_t d_in;

	always_comb begin
		logic [1:0]    e [2];
		logic [1:0]    eb;
		logic [XW-1:0] aa, bb, ll, da, num, dov;
		logic [1:0]    cnt;
		cnt  = {1'b0, btw_s1[0]} + {1'b0, btw_s1[1]} + {1'b0, btw_s1[2]};
		e[0] = btw_s1[0] ? 2'd0 : (btw_s1[1] ? 2'd1 : 2'd2);
		e[1] = btw_s1[0] ? (btw_s1[1] ? 2'd1 : 2'd2) : 2'd2;
		d_in.c.lvl = lvl_s1;
		d_in.c.ax  = ax_s1;
		d_in.c.hit = cnt >= 2'd2;
		ll = {lvl_s1[CW-1], lvl_s1};
		for (int k = 0; k < 2; k++) begin
			eb = (e[k] == 2'd2) ? 2'd0 : e[k] + 2'd1;
			aa = {v_s1[e[k]][ax_s1][CW-1], v_s1[e[k]][ax_s1]};
			bb = {v_s1[eb][ax_s1][CW-1], v_s1[eb][ax_s1]};
			da  = aa - bb;
			num = ll - aa;
			d_in.s[k].sl.a    = v_s1[e[k]];
			d_in.s[k].sl.rneg = num[XW-1] != da[XW-1];
			d_in.s[k].sl.flat = da == '0;
			for (int c = 0; c < NUM_VERT; c++) begin
				dov = {v_s1[e[k]][c][CW-1], v_s1[e[k]][c]} - {v_s1[eb][c][CW-1], v_s1[eb][c]};
				d_in.s[k].sl.dm[c] = mag_x(dov);
				d_in.s[k].sl.dn[c] = dov[XW-1];
			end
			d_in.s[k].rem = mag_x(num);
			d_in.s[k].den = mag_x(da);
			d_in.s[k].q   = '0;
		end
	end

	div_t d_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			d_s2 <= d_in;
		end
	end

	// ---------------------------------------------------------------------
	// Divider stages: one quotient bit each. The first step compares the
	// numerator unshifted (ratio may be exactly one), the rest shift first.
	// ---------------------------------------------------------------------
	div_t div_s [ND];

	for (genvar j = 0; j < ND; j++) begin : g_div
		div_t src, nxt;
		if (j == 0) begin : g_first
			assign src = d_s2;
		end else begin : g_rest
			assign src = div_s[j-1];
		end

		always_comb begin
			logic [XW:0] sh;
			nxt = src;
			for (int k = 0; k < 2; k++) begin
				sh = (j == 0) ? {1'b0, src.s[k].rem} : {src.s[k].rem, 1'b0};
				if (sh >= {1'b0, src.s[k].den}) begin
					nxt.s[k].rem = XW'(sh - {1'b0, src.s[k].den});
					nxt.s[k].q   = {src.s[k].q[QW-2:0], 1'b1};
				end else begin
					nxt.s[k].rem = XW'(sh);
					nxt.s[k].q   = {src.s[k].q[QW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[j] <= nxt;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Multiply stage: ratio times integer and fraction parts of each delta
	// ---------------------------------------------------------------------
	mul_t m_in, m_s3;

	always_comb begin
		m_in.c = div_s[ND-1].c;
		for (int k = 0; k < 2; k++) begin
			m_in.s[k].sl = div_s[ND-1].s[k].sl;
			for (int c = 0; c < NUM_VERT; c++) begin
				m_in.s[k].phi[c] = div_s[ND-1].s[k].q * div_s[ND-1].s[k].sl.dm[c][XW-1:FRAC_BITS];
				m_in.s[k].plo[c] = div_s[ND-1].s[k].q * div_s[ND-1].s[k].sl.dm[c][FRAC_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s3 <= m_in;
		end
	end

	// ---------------------------------------------------------------------
	// Output stage: sum partial products, apply sign, offset from start vertex
	// ---------------------------------------------------------------------
	logic [1:0][NUM_VERT-1:0][CW-1:0] pt;

	always_comb begin
		logic [XW-1:0] m, d;
		for (int k = 0; k < 2; k++) begin
			for (int c = 0; c < NUM_VERT; c++) begin
				m = XW'(m_s3.s[k].phi[c]) + XW'(m_s3.s[k].plo[c] >> FRAC_BITS);
				d = (m_s3.s[k].sl.rneg != m_s3.s[k].sl.dn[c]) ? (~m + 1'b1) : m;
				if (!m_s3.c.hit) begin
					pt[k][c] = '0;
				end else if (c == m_s3.c.ax) begin
					pt[k][c] = m_s3.c.lvl;
				end else if (m_s3.s[k].sl.flat) begin
					pt[k][c] = m_s3.s[k].sl.a[c];
				end else begin
					pt[k][c] = m_s3.s[k].sl.a[c] + d[CW-1:0];
				end
			end
		end
	end

	logic                             hit_s4;
	logic [1:0][NUM_VERT-1:0][CW-1:0] pt_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s4 <= m_s3.c.hit;
			pt_s4  <= pt;
		end
	end

	assign seg.valid = vld_q[NS-1];
	assign seg.hit   = hit_s4;
	assign seg.p0_x  = $signed(pt_s4[0][0]);
	assign seg.p0_y  = $signed(pt_s4[0][1]);
	assign seg.p0_z  = $signed(pt_s4[0][2]);
	assign seg.p1_x  = $signed(pt_s4[1][0]);
	assign seg.p1_y  = $signed(pt_s4[1][1]);
	assign seg.p1_z  = $signed(pt_s4[1][2]);

endmodule
`default_nettype wire
